[src/node_roster_table_defines.svh]
// assertion macros shared by the node roster table modules
// each macro expects clk and arst_n in the scope where it is used
`ifndef NODE_ROSTER_TABLE_DEFINES_SVH
`define NODE_ROSTER_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NRT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("roster table check failed");

// next-cycle implication, checked outside reset
`define NRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("roster table check failed");

`endif

[src/nrt_pkg.sv]
// node roster table package: payload structs, command and status structs, constants
// used by nrt_ctrl, nrt_datapath and node_roster_table; depends on nothing
`default_nettype none

package nrt_pkg;

	localparam int ID_W = 64;
	localparam int TS_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LIVE_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID = 1'b1;

	localparam logic [TS_W-1:0] WINDOW_RESET = 32'd60000;

	// request modes
	localparam logic MODE_NOTE = 1'b0;
	localparam logic MODE_REPORT = 1'b1;

	typedef struct packed {
		logic mode;
		logic [ID_W-1:0] node_id;
		logic node_role;
		logic [TS_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] out_id;
		logic out_role;
		logic last;
	} rslt_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rpt;
		logic rd_en;
		logic s1_adv;
		logic wr_slot;
		logic wr_victim;
		logic vic_upd;
		logic push_entry;
		logic push_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic s1_tok;
		logic s1_hit;
		logic s1_empty;
		logic s1_qual;
		logic s1_last;
		logic more;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[src/nrt_datapath.sv]
// node roster table datapath: entry memory, valid bits, scan stage, victim
// tracking, pending and output result registers; depends on nrt_pkg
`default_nettype none

module nrt_datapath #(
	parameter int ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire nrt_pkg::cmd_t cmd,
	output nrt_pkg::sts_t sts,
	input wire nrt_pkg::item_t item,
	input wire logic cfg_we,
	input wire logic [nrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [nrt_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic rslt_valid,
	output nrt_pkg::rslt_t rslt,
	input wire logic rslt_stall
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int PTR_W = IDX_W + 1;

	// configuration
	logic [nrt_pkg::TS_W-1:0] win_q;
	logic [nrt_pkg::ID_W-1:0] self_q;

	// captured request
	logic [nrt_pkg::ID_W-1:0] it_id_q;
	logic it_role_q;
	logic [nrt_pkg::TS_W-1:0] it_now_q;

	// roster storage
	logic [nrt_pkg::ID_W-1:0] mem_id [ENTRIES];
	logic mem_role [ENTRIES];
	logic [nrt_pkg::TS_W-1:0] mem_stamp [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// scan pointer and read stage
	logic [PTR_W-1:0] ptr_q;
	logic tok_s1;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [nrt_pkg::ID_W-1:0] id_s1;
	logic role_s1;
	logic [nrt_pkg::TS_W-1:0] stamp_s1;

	// eviction candidate
	logic [IDX_W-1:0] vic_idx_q;
	logic [nrt_pkg::TS_W-1:0] vic_stamp_q;
	logic [IDX_W-1:0] vic_idx_nxt;
	logic [nrt_pkg::TS_W-1:0] vic_stamp_nxt;

	// pending and output results
	logic [nrt_pkg::ID_W-1:0] pend_id_q;
	logic pend_role_q;
	logic out_valid_q;
	nrt_pkg::rslt_t out_q;

	logic [nrt_pkg::TS_W-1:0] age;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;

	// status toward the controller
	assign age = it_now_q - stamp_s1;
	assign sts.s1_tok = tok_s1;
	assign sts.s1_hit = vld_s1 && (id_s1 == it_id_q);
	assign sts.s1_empty = !vld_s1;
	assign sts.s1_qual = vld_s1 && (id_s1 != self_q) && (age <= win_q);
	assign sts.s1_last = (idx_s1 == IDX_W'(ENTRIES - 1));
	assign sts.more = (ptr_q < PTR_W'(ENTRIES));
	assign sts.out_free = !out_valid_q || !rslt_stall;

	// victim: slot 0 seeds it, later slots replace it only on a strictly smaller stamp
	always_comb begin
		vic_idx_nxt = vic_idx_q;
		vic_stamp_nxt = vic_stamp_q;
		if ((idx_s1 == '0) || (stamp_s1 < vic_stamp_q)) begin
			vic_idx_nxt = idx_s1;
			vic_stamp_nxt = stamp_s1;
		end
	end

	assign wr_en = cmd.wr_slot || cmd.wr_victim;
	assign wr_addr = cmd.wr_slot ? idx_s1 : vic_idx_nxt;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= nrt_pkg::WINDOW_RESET;
			self_q <= '0;
			valid_q <= '0;
			ptr_q <= '0;
			tok_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nrt_pkg::CFG_LIVE_WINDOW: win_q <= cfg_data[nrt_pkg::TS_W-1:0];
					nrt_pkg::CFG_SELF_ID: self_q <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.accept) begin
				ptr_q <= '0;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.accept) begin
				tok_s1 <= 1'b0;
			end else if (cmd.s1_adv) begin
				tok_s1 <= cmd.rd_en;
			end
			if (cmd.rd_en) begin
				vld_s1 <= valid_q[ptr_q[IDX_W-1:0]];
			end
			if (cmd.push_entry || cmd.push_last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rslt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_id[wr_addr] <= it_id_q;
			mem_role[wr_addr] <= it_role_q;
			mem_stamp[wr_addr] <= it_now_q;
		end
		if (cmd.rd_en) begin
			id_s1 <= mem_id[ptr_q[IDX_W-1:0]];
			role_s1 <= mem_role[ptr_q[IDX_W-1:0]];
			stamp_s1 <= mem_stamp[ptr_q[IDX_W-1:0]];
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			it_id_q <= item.node_id;
			it_role_q <= item.node_role;
			it_now_q <= item.now_ms;
		end
		if (cmd.vic_upd) begin
			vic_idx_q <= vic_idx_nxt;
			vic_stamp_q <= vic_stamp_nxt;
		end
		if (cmd.accept && cmd.rpt) begin
			pend_id_q <= self_q;
			pend_role_q <= item.node_role;
		end else if (cmd.push_entry) begin
			pend_id_q <= id_s1;
			pend_role_q <= role_s1;
		end
		if (cmd.push_entry || cmd.push_last) begin
			out_q.out_id <= pend_id_q;
			out_q.out_role <= pend_role_q;
			out_q.last <= cmd.push_last;
		end
	end

	assign rslt_valid = out_valid_q;
	assign rslt = out_q;

endmodule

`default_nettype wire

[src/nrt_ctrl.sv]
// node roster table controller: sequences note and report scans over the slots
// depends on nrt_pkg and node_roster_table_defines.svh
`default_nettype none

`include "node_roster_table_defines.svh"

module nrt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic acc_mode,
	input wire nrt_pkg::sts_t sts,
	output nrt_pkg::cmd_t cmd,
	output logic busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NOTE = 2'd1;
	localparam logic [1:0] ST_RPT = 2'd2;
	localparam logic [1:0] ST_END = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic fin;
	logic blk;

	assign busy = (state_q != ST_IDLE);

	// command decode and next state
	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.rpt = (acc_mode == nrt_pkg::MODE_REPORT);
		state_nxt = state_q;
		fin = sts.s1_tok && (sts.s1_hit || sts.s1_empty);
		blk = sts.s1_tok && sts.s1_qual && !sts.out_free;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = cmd.rpt ? ST_RPT : ST_NOTE;
				end
			end
			ST_NOTE: begin
				// first match or first empty slot ends the scan, else the oldest stamp is replaced
				cmd.s1_adv = 1'b1;
				cmd.wr_slot = fin;
				cmd.vic_upd = sts.s1_tok && !fin;
				cmd.wr_victim = sts.s1_tok && !fin && sts.s1_last;
				cmd.rd_en = sts.more && !fin;
				if (cmd.wr_slot || cmd.wr_victim) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RPT: begin
				// a qualifying entry pushes the pending result out; hold while output is full
				cmd.s1_adv = !blk;
				cmd.rd_en = !blk && sts.more;
				cmd.push_entry = sts.s1_tok && sts.s1_qual && sts.out_free;
				if (sts.s1_tok && !blk && sts.s1_last) begin
					state_nxt = ST_END;
				end
			end
			ST_END: begin
				// pending result is the final one of the run
				cmd.push_last = sts.out_free;
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// checks
	`NRT_ASSERT_IMPLY(a_single_write, cmd.wr_slot, !cmd.wr_victim)
	`NRT_ASSERT_IMPLY(a_read_in_range, cmd.rd_en, sts.more)
	`NRT_ASSERT_NEXT(a_last_ends_run, cmd.push_last, state_q == ST_IDLE)
	`NRT_ASSERT_IMPLY(a_accept_idle, accept, state_q == ST_IDLE)

endmodule

`default_nettype wire

[src/node_roster_table.sv]
// Node roster table, top level. Joins the controller and the datapath.
// Request channel: item_valid / item_stall / item (mode, node_id, node_role, now_ms).
// A note request (mode 0) scans the slots and updates, fills or evicts one entry;
// it yields no result. A report request (mode 1) yields the own id with the given
// role, then each live entry other than self in slot order; last marks the final one.
// Result channel: rslt_valid / rslt_stall / rslt (out_id, out_role, last).
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, index 0 is the live
// window in ms, index 1 the own id; cfg_ready is always high, write only when idle.
// Slots are read one per cycle from the entry memory unless a report scan is held by a
// stalled result. item_stall stays high for the whole scan, including any pause while
// the result side stalls; a match or an empty slot ends a note scan early.
// A stalled result holds in the output register; the scan pauses on the next live
// entry until the output register frees up. The final result may wait there while
// the next request is taken.
// Reset empties the roster (valid bits cleared), sets the window to 60000 ms and the
// own id to zero.
`default_nettype none

module node_roster_table #(
	parameter int ENTRIES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire nrt_pkg::item_t item,
	output logic rslt_valid,
	input wire logic rslt_stall,
	output nrt_pkg::rslt_t rslt,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [nrt_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [nrt_pkg::CFG_DATA_W-1:0] cfg_data
);

	nrt_pkg::cmd_t cmd;
	nrt_pkg::sts_t sts;
	logic busy;
	logic accept;

	assign item_stall = busy;
	assign accept = item_valid && !busy;
	assign cfg_ready = 1'b1;

	// sequencer
	nrt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.acc_mode(item.mode),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	// storage and result path
	nrt_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.item(item),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rslt_valid(rslt_valid),
		.rslt(rslt),
		.rslt_stall(rslt_stall)
	);

endmodule

`default_nettype wire
